// ===== rtl/core/ptw_pkg.sv =====
package ptw_pkg;

    localparam int PhysBitsDefault = 36;
    localparam int VaBits          = 48;
    localparam int WordBits        = 64;
    localparam int IndexBits       = 9;

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_ENTRY = 1'b1;

    // result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [VaBits-1:0]   virtual_address;
        logic [WordBits-1:0] table_base;
        logic [WordBits-1:0] entry_data;
    } ptw_req_t;

    typedef struct packed {
        logic                result_kind;
        logic [WordBits-1:0] read_address;
        logic [WordBits-1:0] translated_address;
        logic                fault;
    } ptw_res_t;

endpackage

// ===== rtl/core/ptw_if.sv =====
interface ptw_req_if
    import ptw_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                operation;
    logic [VaBits-1:0]   virtual_address;
    logic [WordBits-1:0] table_base;
    logic [WordBits-1:0] entry_data;

    modport source (output valid, output operation, output virtual_address,
                    output table_base, output entry_data, input ready);
    modport sink   (input valid, input operation, input virtual_address,
                    input table_base, input entry_data, output ready);
endinterface

interface ptw_rsp_if
    import ptw_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [WordBits-1:0] read_address;
    logic [WordBits-1:0] translated_address;
    logic                fault;

    modport source (output valid, output result_kind, output read_address,
                    output translated_address, output fault, input ready);
    modport sink   (input valid, input result_kind, input read_address,
                    input translated_address, input fault, output ready);
endinterface

// ===== rtl/core/ptw_in_stage.sv =====
module ptw_in_stage
    import ptw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ptw_req_if.sink   req,
    input  logic      take,
    output logic      item_valid,
    output ptw_req_t  item
);

    logic     valid_reg;
    logic     valid_next;
    ptw_req_t item_reg;

    // accept when empty or when the held request moves on this cycle
    assign req.ready  = !valid_reg || take;
    assign valid_next = req.ready ? req.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.operation       <= req.operation;
            item_reg.virtual_address <= req.virtual_address;
            item_reg.table_base      <= req.table_base;
            item_reg.entry_data      <= req.entry_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/ptw_step.sv =====
module ptw_step
    import ptw_pkg::*;
#(
    parameter int PHYS_BITS = PhysBitsDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  ptw_req_t  item,
    output logic      take,
    ptw_rsp_if.source rsp
);

    localparam logic [1:0] LVL_TOP = 2'd0;
    localparam logic [1:0] LVL_GIG = 2'd1;
    localparam logic [1:0] LVL_MID = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    localparam logic [WordBits-1:0] PhysLimit = (64'd1 << PHYS_BITS) - 64'd1;
    localparam logic [WordBits-1:0] TableMask = PhysLimit & ~64'hfff;
    localparam logic [WordBits-1:0] MidMask   = PhysLimit & ~64'h1f_ffff;
    localparam logic [WordBits-1:0] GigMask   = 64'h000f_ffff_c000_0000;

    logic [1:0]        level_reg, level_next;
    logic              busy_reg, busy_next;
    logic [VaBits-1:0] saved_reg, saved_next;
    logic              out_valid_reg, out_valid_next;
    ptw_res_t          res_reg, res_next;

    logic              fire;
    logic              emit;
    logic [WordBits-1:0] table_addr;
    logic [VaBits-1:0]   va;
    logic [WordBits-1:0] entry;

    assign take = !out_valid_reg || rsp.ready;
    assign fire = item_valid && take;
    assign va    = saved_reg;
    assign entry = item.entry_data;
    assign table_addr = entry & TableMask;

    always_comb
    begin
        level_next = level_reg;
        busy_next  = busy_reg;
        saved_next = saved_reg;
        emit       = 1'b0;
        res_next   = '0;
        if (item.operation == OP_START)
        begin
            saved_next = item.virtual_address;
            busy_next  = 1'b1;
            level_next = LVL_TOP;
            emit       = 1'b1;
            res_next.result_kind  = KIND_READ;
            res_next.read_address = (item.table_base & ~64'hf)
                + WordBits'({item.virtual_address[47:39], 3'b000});
        end
        else if (busy_reg)
        begin
            emit = 1'b1;
            if (!entry[0])
            begin
                res_next.result_kind = KIND_DONE;
                res_next.fault       = 1'b1;
                busy_next  = 1'b0;
                level_next = LVL_TOP;
            end
            else
            begin
                unique case (level_reg)
                    LVL_TOP:
                    begin
                        level_next = LVL_GIG;
                        res_next.result_kind  = KIND_READ;
                        res_next.read_address = table_addr
                            + WordBits'({va[38:30], 3'b000});
                    end
                    LVL_GIG:
                    begin
                        if (entry[7])
                        begin
                            res_next.result_kind        = KIND_DONE;
                            res_next.translated_address = (entry & GigMask)
                                + WordBits'(va[29:0]);
                            busy_next  = 1'b0;
                            level_next = LVL_TOP;
                        end
                        else
                        begin
                            level_next = LVL_MID;
                            res_next.result_kind  = KIND_READ;
                            res_next.read_address = table_addr
                                + WordBits'({va[29:21], 3'b000});
                        end
                    end
                    LVL_MID:
                    begin
                        if (entry[7])
                        begin
                            res_next.result_kind        = KIND_DONE;
                            res_next.translated_address = (entry & MidMask)
                                + WordBits'(va[20:0]);
                            busy_next  = 1'b0;
                            level_next = LVL_TOP;
                        end
                        else
                        begin
                            level_next = LVL_LEAF;
                            res_next.result_kind  = KIND_READ;
                            res_next.read_address = table_addr
                                + WordBits'({va[20:12], 3'b000});
                        end
                    end
                    default:
                    begin
                        res_next.result_kind = KIND_DONE;
                        busy_next  = 1'b0;
                        level_next = LVL_TOP;
                        if (table_addr == '0)
                        begin
                            res_next.fault = 1'b1;
                        end
                        else
                        begin
                            res_next.translated_address = table_addr
                                + WordBits'(va[11:0]);
                        end
                    end
                endcase
            end
        end
    end

    assign out_valid_next = fire ? emit : (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= LVL_TOP;
            busy_reg      <= 1'b0;
            saved_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                level_reg <= level_next;
                busy_reg  <= busy_next;
                saved_reg <= saved_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.result_kind        = res_reg.result_kind;
    assign rsp.read_address       = res_reg.read_address;
    assign rsp.translated_address = res_reg.translated_address;
    assign rsp.fault              = res_reg.fault;

endmodule

// ===== rtl/core/four_level_page_table_walker.sv =====
// Channel  Dir  Carries
// req      in   start (virtual address, table base) or returned table entry
// rsp      out  table read address, or finished translation with fault flag
//
// Each accepted request passes through the input register, then through the
// level decode into the result register. One request is accepted every
// cycle unless rsp stalls; walk state advances as a request leaves
// the input register. Reset clears the walk level, busy flag and saved address.
// A stalled rsp holds its result; req keeps flowing until the input register
// is also full. Entries that arrive with no walk in progress give no result.
module four_level_page_table_walker
    import ptw_pkg::*;
#(
    parameter int PHYS_BITS = PhysBitsDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    ptw_req_if.sink   req,
    ptw_rsp_if.source rsp
);

    logic     item_valid;
    logic     take;
    ptw_req_t item;

    // hold the incoming request until the walk stage can take it
    ptw_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // decode the entry against the current level and register the result
    ptw_step #(
        .PHYS_BITS (PHYS_BITS)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .rsp        (rsp)
    );

endmodule
